### src/farthest_point_k_center_defines.svh
// Assertion macros shared by the farthest-point clustering block
`ifndef FARTHEST_POINT_K_CENTER_DEFINES_SVH
`define FARTHEST_POINT_K_CENTER_DEFINES_SVH

// Implication checked on every rising edge outside reset
`define FPK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define FPK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/fpk_pkg.sv
// ----------------------------------------------------------------------------
// fpk_pkg
// Types, constants and the sequencer state encoding of the clustering block.
// ----------------------------------------------------------------------------
package fpk_pkg;

  localparam int unsigned MaxPoints  = 1024;
  localparam int unsigned MaxCenters = 16;
  localparam int unsigned CoordBits  = 16;
  localparam int unsigned IdxW       = 10;
  localparam int unsigned CidW       = 4;
  localparam int unsigned ErrW       = 2;
  localparam int unsigned KCfgW      = 5;
  localparam logic [KCfgW-1:0] KReset = KCfgW'(8);

  localparam logic [ErrW-1:0] ErrOk    = 2'd0;
  localparam logic [ErrW-1:0] ErrRange = 2'd1;
  localparam logic [ErrW-1:0] ErrDrop  = 2'd2;

  localparam logic ModeLoad  = 1'b0;
  localparam logic ModeQuery = 1'b1;
  localparam logic KindCenter = 1'b0;
  localparam logic KindAnswer = 1'b1;

  typedef struct packed {
    logic                        mode;
    logic signed [CoordBits-1:0] coord_x;
    logic signed [CoordBits-1:0] coord_y;
    logic                        load_last;
    logic [IdxW-1:0]             query_index;
  } in_item_t;

  typedef struct packed {
    logic                        kind;
    logic [CidW-1:0]             cluster_id;
    logic signed [CoordBits-1:0] center_x;
    logic signed [CoordBits-1:0] center_y;
    logic [IdxW-1:0]             center_point;
    logic                        run_last;
    logic [ErrW-1:0]             error;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle,
    StClear,     // clear centre marks
    StScanRd,    // issue read of point i
    StScanCalc,  // point i data valid, distance to newest centre
    StScanUpd,   // update nearest distance and best
    StPick,      // record chosen centre
    StEmitRd,    // read centre j into the output register
    StEmit,      // centre record waiting
    StAsgRd,     // read point for assignment
    StAsgCalc,   // distance to centre j
    StAsgCmp,    // compare and step
    StQryRd,
    StQryCtr,
    StQryOut,
    StOut        // single result waiting
  } state_e;

  // Distance unit control
  typedef struct packed {
    logic load;
  } dist_ctrl_t;

endpackage

### src/fpk_dist.sv
// ----------------------------------------------------------------------------
// fpk_dist
// Shared squared-distance unit, with a register after the squares.
// ----------------------------------------------------------------------------
module fpk_dist #(
  parameter int unsigned CoordBits = fpk_pkg::CoordBits
) (
  input  logic                          clk_i,
  input  fpk_pkg::dist_ctrl_t           ctrl_i,
  input  logic signed [CoordBits-1:0]   ax_i,
  input  logic signed [CoordBits-1:0]   ay_i,
  input  logic signed [CoordBits-1:0]   bx_i,
  input  logic signed [CoordBits-1:0]   by_i,
  output logic [2*CoordBits:0]          dist_o
);
  import fpk_pkg::*;

  logic signed [CoordBits:0] dx, dy;
  logic [CoordBits-1:0]      ux, uy;
  logic [2*CoordBits-1:0]    sx_q, sy_q;

  // absolute differences fit CoordBits unsigned bits
  always_comb begin
    dx = $signed({ax_i[CoordBits-1], ax_i}) - $signed({bx_i[CoordBits-1], bx_i});
    dy = $signed({ay_i[CoordBits-1], ay_i}) - $signed({by_i[CoordBits-1], by_i});
    ux = dx[CoordBits] ? CoordBits'(-dx) : CoordBits'(dx);
    uy = dy[CoordBits] ? CoordBits'(-dy) : CoordBits'(dy);
  end

  // squares registered before the sum
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      sx_q <= ux * ux;
      sy_q <= uy * uy;
    end
  end

  assign dist_o = {1'b0, sx_q} + {1'b0, sy_q};

endmodule

### src/farthest_point_k_center.sv
// ----------------------------------------------------------------------------
// farthest_point_k_center
// Greedy farthest-point k-centre clustering over a stored point set.
// ----------------------------------------------------------------------------
// Input channel in_valid_i / in_stall_o carries load and query items; output
// channel out_valid_o / out_stall_i carries centre records and answers.
// A transfer happens when valid is high and stall low.
// A load that is not last gives nothing; such loads can follow back to back.
// The last load clears the centre marks, runs k-1 scan rounds, then emits the
// centre records one at a time, each held until taken; after the last one the
// points are assigned to their nearest centres. The work is set by the single
// shared distance unit and the one-port point memory.
// A query answer is read through the assignment memory, then the centre list,
// then into the output register.
// The block takes no new item until all work of the current one is done.
// When the receiver stalls, the held record stays put and the sequencer waits.
// Reset empties the set, drops any clustered result and loads k = 8; memory
// contents need no clearing.
// ----------------------------------------------------------------------------
`include "farthest_point_k_center_defines.svh"

module farthest_point_k_center #(
  parameter int unsigned MaxPoints  = fpk_pkg::MaxPoints,
  parameter int unsigned MaxCenters = fpk_pkg::MaxCenters
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [fpk_pkg::KCfgW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fpk_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fpk_pkg::out_item_t  out_data_o
);
  import fpk_pkg::*;

  localparam int unsigned PW = $clog2(MaxPoints);
  localparam int unsigned NW = $clog2(MaxPoints + 1);
  localparam int unsigned CW = $clog2(MaxCenters);
  localparam int unsigned KW = $clog2(MaxCenters + 1);
  localparam int unsigned DW = 2*CoordBits + 1;
  localparam int unsigned QW = (NW > IdxW) ? NW : IdxW;

  // memories
  logic [2*CoordBits-1:0] pt_mem [MaxPoints];
  logic [DW-1:0]          nd_mem [MaxPoints];
  logic [CW-1:0]          as_mem [MaxPoints];
  logic                   mk_mem [MaxPoints];
  logic [PW-1:0]          cl_mem [MaxCenters];

  state_e state_q, state_d;
  logic [NW-1:0] count_q;
  logic          ovf_q, ready_q;
  logic [KCfgW-1:0] kcfg_q;
  logic [KW-1:0] k_q;
  logic [PW-1:0] i_q;
  logic [CW-1:0] j_q;
  logic [PW-1:0] best_q;
  logic [DW-1:0] best_d_q, cur_d_q;
  logic          found_q;
  logic [CW-1:0] cid_q;
  logic [2*CoordBits-1:0] pt_rd_q, ctr_rd_q;
  logic [DW-1:0] nd_rd_q;
  logic          mk_rd_q;
  logic [CW-1:0] as_rd_q;
  logic [PW-1:0] cl_rd_q;
  logic [PW-1:0] qidx_q;
  logic          qok_q;
  out_item_t out_q;
  logic      out_v_q;

  logic in_xfer, out_xfer;
  logic [KW-1:0] k_eff;
  logic [NW-1:0] n_last;
  logic last_pt, last_j;
  dist_ctrl_t dctl;
  logic [DW-1:0] sq_d;
  logic [2*CoordBits-1:0] pa, pb;
  logic [ErrW-1:0] err_set;
  logic [2*CoordBits-1:0] in_pt;
  logic [PW-1:0] wr_idx;
  logic ld_store;
  logic q_ok;
  logic [DW-1:0] nd_new;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // effective k from the register
  always_comb begin
    logic [KCfgW:0] kk;
    logic [NW:0]    kn;
    kk = {1'b0, kcfg_q};
    if (kk == '0) kk = (KCfgW+1)'(1);
    if (kk > (KCfgW+1)'(MaxCenters)) kk = (KCfgW+1)'(MaxCenters);
    kn = (NW+1)'(kk);
    if (kn > {1'b0, count_q}) kn = {1'b0, count_q};
    k_eff = KW'(kn);
  end

  // loop ends
  assign n_last  = count_q - NW'(1);
  assign last_pt = (NW'(i_q) == n_last);
  assign last_j  = ((KW'(j_q) + KW'(1)) == k_q);

  // distance unit
  assign pa = pt_rd_q;
  assign pb = ctr_rd_q;
  fpk_dist #(.CoordBits(CoordBits)) u_dist (
    .clk_i  (clk_i),
    .ctrl_i (dctl),
    .ax_i   (pa[2*CoordBits-1:CoordBits]),
    .ay_i   (pa[CoordBits-1:0]),
    .bx_i   (pb[2*CoordBits-1:CoordBits]),
    .by_i   (pb[CoordBits-1:0]),
    .dist_o (sq_d)
  );

  assign err_set = ovf_q ? ErrDrop : ErrOk;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (in_data_i.mode == ModeQuery) state_d = StQryRd;
          else if (in_data_i.load_last) state_d = StClear;
        end
      end
      StClear: begin
        if (last_pt) state_d = (k_eff > KW'(1)) ? StScanRd : StEmitRd;
      end
      StScanRd:   state_d = StScanCalc;
      StScanCalc: state_d = StScanUpd;
      StScanUpd:  state_d = last_pt ? StPick : StScanRd;
      StPick:     state_d = last_j ? StEmitRd : StScanRd;
      StEmitRd:   state_d = StEmit;
      StEmit: begin
        if (out_xfer) state_d = last_j ? StAsgRd : StEmitRd;
      end
      StAsgRd:   state_d = StAsgCalc;
      StAsgCalc: state_d = StAsgCmp;
      StAsgCmp:  state_d = last_j ? (last_pt ? StIdle : StAsgRd) : StAsgCalc;
      StQryRd:   state_d = StQryCtr;
      StQryCtr:  state_d = StQryOut;
      StQryOut:  state_d = StOut;
      StOut: begin
        if (out_xfer) state_d = StIdle;
      end
      default:   state_d = StIdle;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = (state_q != StIdle);
    dctl.load  = (state_q == StScanCalc) || (state_q == StAsgCalc);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      ovf_q   <= 1'b0;
      ready_q <= 1'b0;
      kcfg_q  <= KReset;
      k_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      out_v_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) kcfg_q <= cfg_wdata_i;
      case (state_q)
        StIdle: begin
          i_q <= '0;
          j_q <= '0;
          if (in_xfer && in_data_i.mode == ModeLoad) begin
            if (ready_q) begin
              count_q <= NW'(1);
              ovf_q   <= 1'b0;
              ready_q <= 1'b0;
            end else if (count_q < NW'(MaxPoints)) begin
              count_q <= count_q + NW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
          end
        end
        StClear: begin
          k_q     <= k_eff;
          found_q <= 1'b0;
          if (last_pt) begin
            i_q <= '0;
            j_q <= (k_eff > KW'(1)) ? CW'(1) : '0;
          end else begin
            i_q <= i_q + PW'(1);
          end
        end
        StScanUpd: begin
          if (!mk_rd_q) found_q <= 1'b1;
          i_q <= last_pt ? '0 : i_q + PW'(1);
        end
        StPick: begin
          found_q <= 1'b0;
          j_q <= last_j ? '0 : j_q + CW'(1);
        end
        StEmitRd: out_v_q <= 1'b1;
        StEmit: begin
          if (out_xfer) begin
            out_v_q <= 1'b0;
            if (last_j) begin
              j_q <= '0;
              i_q <= '0;
              ready_q <= 1'b1;
            end else begin
              j_q <= j_q + CW'(1);
            end
          end
        end
        StAsgCmp: begin
          if (last_j) begin
            j_q <= '0;
            i_q <= i_q + PW'(1);
          end else begin
            j_q <= j_q + CW'(1);
          end
        end
        StQryOut: out_v_q <= 1'b1;
        StOut: begin
          if (out_xfer) out_v_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // load and query helpers
  assign in_pt    = {in_data_i.coord_x, in_data_i.coord_y};
  assign wr_idx   = ready_q ? '0 : PW'(count_q);
  assign ld_store = ready_q || (count_q < NW'(MaxPoints));
  assign q_ok     = ready_q && (QW'(in_data_i.query_index) < QW'(count_q));

  // nearest distance after this round
  always_comb begin
    nd_new = (j_q == CW'(1) || sq_d < nd_rd_q) ? sq_d : nd_rd_q;
  end

  // memories and datapath (no reset)
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (in_xfer && in_data_i.mode == ModeLoad && ld_store)
          pt_mem[wr_idx] <= in_pt;
        qok_q  <= q_ok;
        qidx_q <= PW'(in_data_i.query_index);
      end
      StClear: begin
        mk_mem[i_q] <= (i_q == '0);
        cl_mem[0]   <= '0;
        ctr_rd_q    <= pt_mem[0];
      end
      StScanRd: begin
        pt_rd_q <= pt_mem[i_q];
        nd_rd_q <= nd_mem[i_q];
        mk_rd_q <= mk_mem[i_q];
      end
      StScanUpd: begin
        if (!mk_rd_q) begin
          nd_mem[i_q] <= nd_new;
          if (!found_q || nd_new > best_d_q) begin
            best_d_q <= nd_new;
            best_q   <= i_q;
          end
        end
      end
      StPick: begin
        cl_mem[j_q]    <= best_q;
        mk_mem[best_q] <= 1'b1;
        ctr_rd_q       <= pt_mem[best_q];
      end
      StEmitRd: begin
        out_q.kind         <= KindCenter;
        out_q.cluster_id   <= CidW'(j_q);
        {out_q.center_x, out_q.center_y} <= pt_mem[cl_mem[j_q]];
        out_q.center_point <= IdxW'(cl_mem[j_q]);
        out_q.run_last     <= last_j;
        out_q.error        <= err_set;
      end
      StAsgRd: begin
        pt_rd_q  <= pt_mem[i_q];
        ctr_rd_q <= pt_mem[cl_mem[j_q]];
      end
      StAsgCmp: begin
        if (j_q == '0 || sq_d < cur_d_q) begin
          cur_d_q <= sq_d;
          cid_q   <= j_q;
          if (last_j) as_mem[i_q] <= j_q;
        end else if (last_j) as_mem[i_q] <= cid_q;
        if (!last_j) ctr_rd_q <= pt_mem[cl_mem[j_q + CW'(1)]];
      end
      StQryRd:  as_rd_q <= as_mem[qidx_q];
      StQryCtr: cl_rd_q <= cl_mem[as_rd_q];
      StQryOut: begin
        out_q.kind     <= KindAnswer;
        out_q.run_last <= 1'b1;
        if (qok_q) begin
          out_q.cluster_id   <= CidW'(as_rd_q);
          {out_q.center_x, out_q.center_y} <= pt_mem[cl_rd_q];
          out_q.center_point <= IdxW'(cl_rd_q);
          out_q.error        <= err_set;
        end else begin
          out_q.cluster_id   <= '0;
          {out_q.center_x, out_q.center_y} <= '0;
          out_q.center_point <= '0;
          out_q.error        <= ErrRange;
        end
      end
      default: ;
    endcase
  end

  // checks
  `FPK_ASSERT_IMP(a_stall_busy, state_q != StIdle, in_stall_o, "input taken while busy")
  `FPK_ASSERT_IMP(a_out_state, out_valid_o, state_q == StEmit || state_q == StOut, "stray valid")
  `FPK_ASSERT_NEXT(a_query_out, state_q == StQryOut, out_valid_o, "query answer lost")
  `FPK_ASSERT_NEXT(a_out_hold, out_v_q && out_stall_i, out_v_q && $stable(out_q), "record moved")

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the farthest-point k-centre block: a short table of
// directed loads and queries, k-register corner cases, then random point sets
// with query bursts, results compared against an in-bench greedy clustering predictor or the table's own expectation.
// ----------------------------------------------------------------------------
module testbench;
  import fpk_pkg::*;

  localparam int unsigned LimitCycles = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [KCfgW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;

  farthest_point_k_center dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  // Predictor state
  logic signed [CoordBits-1:0] pt_x [MaxPoints];
  logic signed [CoordBits-1:0] pt_y [MaxPoints];
  logic [63:0] near_d [MaxPoints];
  bit is_centre [MaxPoints];
  int unsigned centre_idx [MaxCenters];
  int unsigned cluster_of [MaxPoints];
  int unsigned pt_count, k_live;
  bit dropped, clustered;
  logic [KCfgW-1:0] k_reg;

  out_item_t expected_q [$];
  int unsigned mismatches, cycles;
  int unsigned out_wait, out_draw;
  bit failed;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [63:0] sq_dist(int unsigned a, int unsigned b);
    logic signed [63:0] dx, dy;
    dx = 64'(pt_x[a]) - 64'(pt_x[b]);
    dy = 64'(pt_y[a]) - 64'(pt_y[b]);
    return dx * dx + dy * dy;
  endfunction

  function automatic out_item_t centre_rec(logic kind, int unsigned cid, logic last);
    out_item_t r;
    r.kind = kind;
    r.cluster_id = CidW'(cid);
    r.center_x = pt_x[centre_idx[cid]];
    r.center_y = pt_y[centre_idx[cid]];
    r.center_point = IdxW'(centre_idx[cid]);
    r.run_last = last;
    r.error = dropped ? ErrDrop : ErrOk;
    return r;
  endfunction

  // Append one expectation
  task automatic exp_add(out_item_t r);
    expected_q.insert(expected_q.size(), r);
  endtask

  // Greedy farthest-point selection, then nearest-centre assignment
  task automatic run_clustering();
    int unsigned k, best;
    logic [63:0] d, best_d;
    bit found;
    k = (k_reg < 1) ? 1 : k_reg;
    if (k > MaxCenters) k = MaxCenters;
    if (k > pt_count) k = pt_count;
    for (int unsigned i = 0; i < pt_count; i++) is_centre[i] = 0;
    centre_idx[0] = 0;
    is_centre[0] = 1;
    for (int unsigned j = 1; j < k; j++) begin
      found = 0; best = 0; best_d = 0;
      for (int unsigned i = 0; i < pt_count; i++) begin
        if (is_centre[i]) continue;
        d = sq_dist(i, centre_idx[j-1]);
        if (j == 1 || d < near_d[i]) near_d[i] = d;
        if (!found || near_d[i] > best_d) begin
          found = 1; best_d = near_d[i]; best = i;
        end
      end
      centre_idx[j] = best;
      is_centre[best] = 1;
    end
    for (int unsigned i = 0; i < pt_count; i++) begin
      best_d = sq_dist(i, centre_idx[0]);
      best = 0;
      for (int unsigned j = 1; j < k; j++) begin
        d = sq_dist(i, centre_idx[j]);
        if (d < best_d) begin best_d = d; best = j; end
      end
      cluster_of[i] = best;
    end
    k_live = k;
    clustered = 1;
    for (int unsigned j = 0; j < k; j++) exp_add(centre_rec(KindCenter, j, j == k - 1));
  endtask

  task automatic predict(in_item_t it);
    out_item_t r;
    if (it.mode == ModeLoad) begin
      if (clustered) begin
        pt_count = 0; dropped = 0; clustered = 0;
      end
      if (pt_count < MaxPoints) begin
        pt_x[pt_count] = it.coord_x;
        pt_y[pt_count] = it.coord_y;
        pt_count++;
      end else begin
        dropped = 1;
      end
      if (it.load_last) run_clustering();
    end else if (!clustered || it.query_index >= pt_count) begin
      r = '0;
      r.kind = KindAnswer;
      r.run_last = 1'b1;
      r.error = ErrRange;
      exp_add(r);
    end else begin
      exp_add(centre_rec(KindAnswer, cluster_of[it.query_index], 1'b1));
    end
  endtask

  // Output side: random wait per result, compare each transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          failed <= 1'b1;
          if (mismatches < 10) $display("Unexpected result %p", out_data_o);
          mismatches <= mismatches + 1;
        end else begin
          if (out_data_o !== expected_q[0]) begin
            failed <= 1'b1;
            if (mismatches < 10)
              $display("Mismatch: expected %p, got %p", expected_q[0], out_data_o);
            mismatches <= mismatches + 1;
          end
          void'(expected_q.pop_front());
        end
        out_draw = $urandom_range(0, 10);
        out_wait <= out_draw;
        out_stall_i <= (out_draw != 0);
      end else if (out_wait > 0) begin
        out_wait <= out_wait - 1;
        out_stall_i <= (out_wait > 1);
      end
    end
  end

  // Drive one item, with a random gap before it, and wait for its transfer
  task automatic send(in_item_t it);
    int unsigned gap;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict(it);
  endtask

  // Drop the input valid and wait for a clock edge
  task automatic hold_off();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic in_item_t mk_load(int x, int y, bit last);
    in_item_t it;
    it = '0;
    it.mode = ModeLoad;
    it.coord_x = CoordBits'(x);
    it.coord_y = CoordBits'(y);
    it.load_last = last;
    it.query_index = IdxW'($urandom);
    return it;
  endfunction

  function automatic in_item_t mk_query(int unsigned q);
    in_item_t it;
    it = '0;
    it.mode = ModeQuery;
    it.coord_x = CoordBits'($urandom);
    it.coord_y = CoordBits'($urandom);
    it.load_last = 1'($urandom);
    it.query_index = IdxW'(q);
    return it;
  endfunction

  // Idle the block and write k
  task automatic set_k(logic [KCfgW-1:0] k);
    hold_off();
    while (expected_q.size() != 0) @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= k;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    k_reg = k;
  endtask

  typedef struct {
    in_item_t item;
    bit has_exp;
    out_item_t exp_item;
  } dir_row_t;

  initial begin
    dir_row_t rows [$];
    dir_row_t row;
    out_item_t range_err;
    int unsigned n, ksel;
    pt_count = 0; dropped = 0; clustered = 0; k_reg = KReset;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    range_err = '0;
    range_err.kind = KindAnswer;
    range_err.run_last = 1'b1;
    range_err.error = ErrRange;

    // Directed table: query before any set, extremes, duplicates, out-of-range
    row.has_exp = 1; row.exp_item = range_err; row.item = mk_query(0);
    rows.insert(rows.size(), row);
    row.has_exp = 0;
    row.item = mk_load(-32768, -32768, 0); rows.insert(rows.size(), row);
    row.item = mk_load(32767, 32767, 0); rows.insert(rows.size(), row);
    row.item = mk_load(32767, -32768, 0); rows.insert(rows.size(), row);
    row.item = mk_load(-32768, -32768, 0); rows.insert(rows.size(), row);
    row.item = mk_load(0, 0, 0); rows.insert(rows.size(), row);
    row.item = mk_load(-1, 1, 1); rows.insert(rows.size(), row);
    for (int q = 0; q < 6; q++) begin
      row.item = mk_query(q); rows.insert(rows.size(), row);
    end
    row.has_exp = 1; row.item = mk_query(6); rows.insert(rows.size(), row);
    row.item = mk_query(1023); rows.insert(rows.size(), row);
    row.has_exp = 0;
    // single point set gives one centre at point 0
    row.item = mk_load(123, -456, 1); rows.insert(rows.size(), row);
    row.item = mk_query(0); rows.insert(rows.size(), row);
    row.has_exp = 1; row.item = mk_query(1); rows.insert(rows.size(), row);

    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        hold_off();
        while (expected_q.size() != 0) @(posedge clk_i);
        send(rows[i].item);
        expected_q[expected_q.size()-1] = rows[i].exp_item;
      end else begin
        send(rows[i].item);
      end
    end

    // Duplicates of every point with k at maximum, then register values above it and zero
    set_k(5'd16);
    for (int i = 0; i < 6; i++) send(mk_load(i % 3, 7, i == 5));
    for (int q = 0; q < 6; q++) send(mk_query(q));
    set_k(5'd31);
    for (int i = 0; i < 20; i++) send(mk_load($urandom, $urandom, i == 19));
    send(mk_query(19));
    set_k(5'd0);
    for (int i = 0; i < 4; i++) send(mk_load($urandom, $urandom, i == 3));
    send(mk_query(2));

    // Random sets with query bursts, k varied between them
    for (int s = 0; s < 30; s++) begin
      ksel = $urandom_range(0, 4);
      set_k(ksel == 0 ? 5'd1 : ksel == 1 ? 5'd16 : KCfgW'($urandom_range(0, 31)));
      n = $urandom_range(1, 14);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 4) == 0)
          send(mk_load($urandom_range(0, 1) ? -32768 : 32767, $urandom, i == n - 1));
        else
          send(mk_load($urandom, $urandom, i == n - 1));
      end
      repeat ($urandom_range(2, 8)) begin
        send(mk_query($urandom_range(0, 7) == 0 ? $urandom_range(0, 1023)
                                                : $urandom_range(0, n - 1)));
      end
    end

    hold_off();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (!failed && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
